[rtl/indexed_min_heap_run_queue_core_assert.svh]
// Assertion macros for the indexed min-heap run queue.
// Used by the datapath; needs clk_i and rst_ni in the scope that uses them.
`ifndef INDEXED_MIN_HEAP_RUN_QUEUE_CORE_ASSERT_SVH
`define INDEXED_MIN_HEAP_RUN_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IMHRQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define IMHRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IMHRQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define IMHRQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/imhrq_pkg.sv]
// Shared types and constants of the indexed min-heap run queue.
// No dependencies.
package imhrq_pkg;

  localparam int unsigned NUM_HANDLES = 64;
  localparam int unsigned HANDLE_W    = 6;
  localparam int unsigned KEY_W       = 48;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_W     = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_POP    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_REKEY  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_NOT_QUEUED = 3'd3,
    ST_ALREADY    = 3'd4,
    ST_NO_WORK    = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic decode;
    logic take_key;
    logic take;
    logic rd_parent;
    logic rd_parent_key;
    logic up_swap;
    logic rd_children;
    logic rd_child_keys;
    logic down_swap;
    logic place;
    logic rd_root;
    logic rd_root_key;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  dec_err;
    func_e func;
    logic  pos_root;
    logic  parent_gt;
    logic  left_ok;
    logic  down_go;
    logic  take_last;
    logic  cnt_zero;
    logic  out_free;
  } sts_t;

endpackage

[rtl/imhrq_ifs.sv]
// Handshake interfaces for the request and result channels.
// Depends on imhrq_pkg for field widths.
interface imhrq_req_if;
  logic                              valid;
  logic                              ready;
  logic [imhrq_pkg::FUNC_W-1:0]      func;
  logic [imhrq_pkg::HANDLE_W-1:0]    handle;
  logic [imhrq_pkg::KEY_W-1:0]       key;
  logic                              runnable;
  modport source (output valid, func, handle, key, runnable, input ready);
  modport sink (input valid, func, handle, key, runnable, output ready);
endinterface

interface imhrq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [imhrq_pkg::STATUS_W-1:0]    status;
  logic                              out_valid;
  logic [imhrq_pkg::HANDLE_W-1:0]    out_handle;
  logic [imhrq_pkg::KEY_W-1:0]       out_key;
  logic                              min_valid;
  logic [imhrq_pkg::HANDLE_W-1:0]    min_handle;
  logic [imhrq_pkg::KEY_W-1:0]       min_key;
  logic [imhrq_pkg::COUNT_W-1:0]     count;
  modport source (output valid, status, out_valid, out_handle, out_key, min_valid,
                  min_handle, min_key, count, input ready);
  modport sink (input valid, status, out_valid, out_handle, out_key, min_valid,
                min_handle, min_key, count, output ready);
endinterface

[rtl/indexed_min_heap_run_queue_core.sv]
// Top level of the indexed min-heap run queue: controller plus datapath.
// Depends on imhrq_pkg, imhrq_ifs, imhrq_ctrl and imhrq_dp.
//
//   Channel  Direction  Handshake     Carries
//   req_i    in         valid/ready   func, handle, key, runnable
//   rsp_o    out        valid/ready   status, left handle/key, minimum, count
//
// After acceptance an item goes through decode, a sift of parent or child compares
// that ends at the root or a leaf, placement, root read-back, emit and idle; pop and
// remove add a key read and a take before the sift, and a refused item goes from decode
// to the root read-back.
// Reset clears the queued flags and count at once; no memory sweep follows.
// A request is taken only while the controller is idle; a result waits in its
// output register, and a later item finishes only once that register is free.
module indexed_min_heap_run_queue_core #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  imhrq_req_if.sink   req_i,
  imhrq_rsp_if.source rsp_o
);

  imhrq_pkg::cmd_t cmd;
  imhrq_pkg::sts_t sts;
  logic            req_ready;

  // Sequencing.
  imhrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // Storage and arithmetic.
  imhrq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (req_i.func),
    .handle_i     (req_i.handle),
    .key_i        (req_i.key),
    .runnable_i   (req_i.runnable),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .out_valid_o  (rsp_o.out_valid),
    .out_handle_o (rsp_o.out_handle),
    .out_key_o    (rsp_o.out_key),
    .min_valid_o  (rsp_o.min_valid),
    .min_handle_o (rsp_o.min_handle),
    .min_key_o    (rsp_o.min_key),
    .count_o      (rsp_o.count)
  );

endmodule

[rtl/imhrq_ctrl.sv]
// Controller state machine of the run queue: sequences decode, removal and sifts.
// Depends on imhrq_pkg for the command and status structs.
module imhrq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  imhrq_pkg::sts_t   sts_i,
  output imhrq_pkg::cmd_t   cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECODE = 13'b0000000000010,
    S_LOADK  = 13'b0000000000100,
    S_TAKE   = 13'b0000000001000,
    S_SET    = 13'b0000000010000,
    S_PH     = 13'b0000000100000,
    S_PK     = 13'b0000001000000,
    S_CH     = 13'b0000010000000,
    S_CK     = 13'b0000100000000,
    S_PLACE  = 13'b0001000000000,
    S_ROOT   = 13'b0010000000000,
    S_RKEY   = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_e;

  // First check looks at the parent, then settles on a direction.
  typedef enum logic [1:0] {
    MD_FIRST = 2'd0,
    MD_UP    = 2'd1,
    MD_DOWN  = 2'd2
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  assign req_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        mode_d       = MD_FIRST;
        if (sts_i.dec_err) begin
          state_d = S_ROOT;
        end else begin
          case (sts_i.func)
            imhrq_pkg::FN_INSERT, imhrq_pkg::FN_REKEY: state_d = S_SET;
            imhrq_pkg::FN_POP, imhrq_pkg::FN_REMOVE:   state_d = S_LOADK;
            default:                                   state_d = S_ROOT;
          endcase
        end
      end
      S_LOADK: begin
        cmd_o.take_key = 1'b1;
        state_d        = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        mode_d     = MD_FIRST;
        state_d    = sts_i.take_last ? S_ROOT : S_SET;
      end
      S_SET: begin
        if (mode_q == MD_DOWN) begin
          if (sts_i.left_ok) begin
            cmd_o.rd_children = 1'b1;
            state_d           = S_CH;
          end else begin
            state_d = S_PLACE;
          end
        end else if (!sts_i.pos_root) begin
          cmd_o.rd_parent = 1'b1;
          state_d         = S_PH;
        end else if (mode_q == MD_FIRST) begin
          mode_d = MD_DOWN;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PH: begin
        cmd_o.rd_parent_key = 1'b1;
        state_d             = S_PK;
      end
      S_PK: begin
        if (sts_i.parent_gt) begin
          cmd_o.up_swap = 1'b1;
          mode_d        = MD_UP;
          state_d       = S_SET;
        end else if (mode_q == MD_FIRST) begin
          mode_d  = MD_DOWN;
          state_d = S_SET;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_CH: begin
        cmd_o.rd_child_keys = 1'b1;
        state_d             = S_CK;
      end
      S_CK: begin
        if (sts_i.down_go) begin
          cmd_o.down_swap = 1'b1;
          state_d         = S_SET;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_ROOT;
      end
      S_ROOT: begin
        if (sts_i.cnt_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd_root = 1'b1;
          state_d       = S_RKEY;
        end
      end
      S_RKEY: begin
        cmd_o.rd_root_key = 1'b1;
        state_d           = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MD_FIRST;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

[rtl/imhrq_dp.sv]
// Datapath of the run queue: heap, key and slot memories, queued flags and result register.
// Depends on imhrq_pkg and the assertion macro header.
`include "indexed_min_heap_run_queue_core_assert.svh"

module imhrq_dp #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [imhrq_pkg::FUNC_W-1:0]      func_i,
  input  logic [imhrq_pkg::HANDLE_W-1:0]    handle_i,
  input  logic [imhrq_pkg::KEY_W-1:0]       key_i,
  input  logic                              runnable_i,
  input  imhrq_pkg::cmd_t                   cmd_i,
  output imhrq_pkg::sts_t                   sts_o,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic [imhrq_pkg::STATUS_W-1:0]    status_o,
  output logic                              out_valid_o,
  output logic [imhrq_pkg::HANDLE_W-1:0]    out_handle_o,
  output logic [imhrq_pkg::KEY_W-1:0]       out_key_o,
  output logic                              min_valid_o,
  output logic [imhrq_pkg::HANDLE_W-1:0]    min_handle_o,
  output logic [imhrq_pkg::KEY_W-1:0]       min_key_o,
  output logic [imhrq_pkg::COUNT_W-1:0]     count_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = IW + 2;
  localparam int unsigned HW = imhrq_pkg::HANDLE_W;
  localparam int unsigned NH = imhrq_pkg::NUM_HANDLES;
  localparam int unsigned KW = imhrq_pkg::KEY_W;
  localparam int unsigned OW = imhrq_pkg::COUNT_W;

  // Memories.
  logic [HW-1:0]       heap_mem [CAPACITY];
  logic [KEY_BITS-1:0] key_mem  [NH];
  logic [IW-1:0]       slot_mem [NH];

  // Control state.
  logic [NH-1:0] queued_q;
  logic [CW-1:0] cnt_q;
  logic          rsp_valid_q;

  // Payload registers.
  imhrq_pkg::func_e   func_q;
  logic [HW-1:0]      h_q;
  logic [KEY_BITS-1:0] key_q;
  logic               work_q;
  imhrq_pkg::status_e status_q;
  logic               ov_q;
  logic [HW-1:0]      oh_q;
  logic [KEY_BITS-1:0] ok_q;
  logic [IW-1:0]      pos_q;
  logic [HW-1:0]      ch_q;
  logic [KEY_BITS-1:0] ck_q;
  logic [HW-1:0]      hrd_a_q, hrd_b_q;
  logic [KEY_BITS-1:0] krd_a_q, krd_b_q;
  logic [IW-1:0]      srd_q;

  // Result register.
  logic [imhrq_pkg::STATUS_W-1:0] rsp_status_q;
  logic                           rsp_ov_q;
  logic [HW-1:0]                  rsp_oh_q;
  logic [KW-1:0]                  rsp_ok_q;
  logic                           rsp_mv_q;
  logic [HW-1:0]                  rsp_mh_q;
  logic [KW-1:0]                  rsp_mk_q;
  logic [OW-1:0]                  rsp_cnt_q;

  // Combinational signals.
  logic [KEY_BITS+KW-1:0] key_in_ext, ok_ext, mk_ext;
  logic [KEY_BITS-1:0]    key_in;
  logic [CW+OW-1:0]       cnt_ext;
  logic [IW-1:0]          pos_m1, parent_idx, left_idx, right_idx, child_idx;
  logic [PW-1:0]          left_w, right_w;
  logic                   left_ok, right_ok, right_sel;
  logic [CW-1:0]          cnt_m1;
  logic [IW-1:0]          last_idx, take_pos;
  logic                   pop_sel, dec_ok, cap_full;
  logic [HW-1:0]          rm_h, ch_h;
  imhrq_pkg::status_e     dec_status;
  logic                   heap_we;
  logic [HW-1:0]          heap_wd;
  logic                   key_we;
  logic                   hra_en, hrb_en, kra_en, krb_en;
  logic [IW-1:0]          hra_addr, hrb_addr;
  logic [HW-1:0]          kra_addr;

  // Key width adaption in both directions.
  assign key_in_ext = {{KEY_BITS{1'b0}}, key_i};
  assign key_in     = key_in_ext[KEY_BITS-1:0];
  assign ok_ext     = {{KW{1'b0}}, ok_q};
  assign mk_ext     = {{KW{1'b0}}, krd_a_q};
  assign cnt_ext    = {{OW{1'b0}}, cnt_q};

  // Heap index arithmetic.
  assign pos_m1     = pos_q - IW'(1);
  assign parent_idx = pos_m1 >> 1;
  assign left_w     = PW'({pos_q, 1'b1});
  assign right_w    = left_w + PW'(1);
  assign left_idx   = left_w[IW-1:0];
  assign right_idx  = right_w[IW-1:0];
  assign left_ok    = left_w < PW'(cnt_q);
  assign right_ok   = right_w < PW'(cnt_q);
  assign cnt_m1     = cnt_q - CW'(1);
  assign last_idx   = cnt_m1[IW-1:0];
  assign cap_full   = cnt_q >= CW'(CAPACITY);

  // Removal: pop takes the root, remove takes the handle's own slot.
  assign pop_sel  = (func_q == imhrq_pkg::FN_POP);
  assign take_pos = pop_sel ? '0 : srd_q;
  assign rm_h     = pop_sel ? hrd_a_q : h_q;

  // Child choice: the right child only when the left key is strictly greater.
  assign right_sel = right_ok && (krd_a_q > krd_b_q);
  assign ch_h      = right_sel ? hrd_b_q : hrd_a_q;
  assign child_idx = right_sel ? right_idx : left_idx;

  // Decode of the request against the queue state.
  always_comb begin
    dec_status = imhrq_pkg::ST_OK;
    case (func_q)
      imhrq_pkg::FN_INSERT: begin
        if (!work_q) begin
          dec_status = imhrq_pkg::ST_NO_WORK;
        end else if (queued_q[h_q]) begin
          dec_status = imhrq_pkg::ST_ALREADY;
        end else if (cap_full) begin
          dec_status = imhrq_pkg::ST_FULL;
        end
      end
      imhrq_pkg::FN_POP: begin
        if (cnt_q == '0) begin
          dec_status = imhrq_pkg::ST_EMPTY;
        end
      end
      imhrq_pkg::FN_REMOVE, imhrq_pkg::FN_REKEY: begin
        if (!queued_q[h_q]) begin
          dec_status = imhrq_pkg::ST_NOT_QUEUED;
        end
      end
      default: begin
        dec_status = imhrq_pkg::ST_OK;
      end
    endcase
  end
  assign dec_ok = (dec_status == imhrq_pkg::ST_OK);

  // Memory port selection.
  assign heap_we  = cmd_i.up_swap | cmd_i.down_swap | cmd_i.place;
  assign heap_wd  = cmd_i.up_swap ? hrd_a_q : (cmd_i.down_swap ? ch_h : ch_q);
  assign key_we   = cmd_i.decode && dec_ok &&
                    ((func_q == imhrq_pkg::FN_INSERT) || (func_q == imhrq_pkg::FN_REKEY));
  assign hra_en   = cmd_i.decode | cmd_i.rd_parent | cmd_i.rd_children | cmd_i.rd_root;
  assign hra_addr = cmd_i.rd_parent ? parent_idx : (cmd_i.rd_children ? left_idx : '0);
  assign hrb_en   = cmd_i.decode | cmd_i.rd_children;
  assign hrb_addr = cmd_i.rd_children ? right_idx : last_idx;
  assign kra_en   = cmd_i.take_key | cmd_i.rd_parent_key | cmd_i.rd_child_keys |
                    cmd_i.rd_root_key;
  assign kra_addr = (cmd_i.take_key && !pop_sel) ? h_q : hrd_a_q;
  assign krb_en   = cmd_i.take_key | cmd_i.rd_child_keys;

  // Heap memory with two registered read ports.
  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[pos_q] <= heap_wd;
    end
    if (hra_en) begin
      hrd_a_q <= heap_mem[hra_addr];
    end
    if (hrb_en) begin
      hrd_b_q <= heap_mem[hrb_addr];
    end
  end

  // Key memory with two registered read ports.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[h_q] <= key_q;
    end
    if (kra_en) begin
      krd_a_q <= key_mem[kra_addr];
    end
    if (krb_en) begin
      krd_b_q <= key_mem[hrd_b_q];
    end
  end

  // Slot memory; a handle's slot follows every heap write.
  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      slot_mem[heap_wd] <= pos_q;
    end
    if (cmd_i.latch_in) begin
      srd_q <= slot_mem[handle_i];
    end
  end

  // Queued flags, count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q    <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decode && dec_ok && (func_q == imhrq_pkg::FN_INSERT)) begin
        queued_q[h_q] <= 1'b1;
        cnt_q         <= cnt_q + CW'(1);
      end
      if (cmd_i.take) begin
        queued_q[rm_h] <= 1'b0;
        cnt_q          <= cnt_m1;
      end
      if (cmd_i.emit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= imhrq_pkg::func_e'(func_i);
      h_q    <= handle_i;
      key_q  <= key_in;
      work_q <= runnable_i;
    end
    if (cmd_i.decode) begin
      status_q <= dec_status;
      ov_q     <= 1'b0;
      oh_q     <= '0;
      ok_q     <= '0;
      ch_q     <= h_q;
      ck_q     <= key_q;
      pos_q    <= (func_q == imhrq_pkg::FN_INSERT) ? cnt_q[IW-1:0] : srd_q;
    end
    if (cmd_i.take) begin
      ov_q  <= 1'b1;
      oh_q  <= rm_h;
      ok_q  <= krd_a_q;
      pos_q <= take_pos;
      ch_q  <= hrd_b_q;
      ck_q  <= krd_b_q;
    end
    if (cmd_i.up_swap) begin
      pos_q <= parent_idx;
    end
    if (cmd_i.down_swap) begin
      pos_q <= child_idx;
    end
    if (cmd_i.emit) begin
      rsp_status_q <= status_q;
      rsp_ov_q     <= ov_q;
      rsp_oh_q     <= oh_q;
      rsp_ok_q     <= ok_ext[KW-1:0];
      rsp_mv_q     <= (cnt_q != '0);
      rsp_mh_q     <= (cnt_q != '0) ? hrd_a_q : '0;
      rsp_mk_q     <= (cnt_q != '0) ? mk_ext[KW-1:0] : '0;
      rsp_cnt_q    <= cnt_ext[OW-1:0];
    end
  end

  // Status towards the controller.
  assign sts_o.dec_err   = !dec_ok;
  assign sts_o.func      = func_q;
  assign sts_o.pos_root  = (pos_q == '0);
  assign sts_o.parent_gt = (krd_a_q > ck_q);
  assign sts_o.left_ok   = left_ok;
  assign sts_o.down_go   = right_sel ? (ck_q > krd_b_q) : (ck_q > krd_a_q);
  assign sts_o.take_last = (take_pos == last_idx);
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

  // Result outputs.
  assign rsp_valid_o  = rsp_valid_q;
  assign status_o     = rsp_status_q;
  assign out_valid_o  = rsp_ov_q;
  assign out_handle_o = rsp_oh_q;
  assign out_key_o    = rsp_ok_q;
  assign min_valid_o  = rsp_mv_q;
  assign min_handle_o = rsp_mh_q;
  assign min_key_o    = rsp_mk_q;
  assign count_o      = rsp_cnt_q;

  // Checks on queue bookkeeping.
  `IMHRQ_ASSERT_IMPL(a_cnt_matches_flags, 1'b1, $countones(queued_q) == cnt_q, "count vs flags")
  `IMHRQ_ASSERT_IMPL(a_cnt_bounded, 1'b1, cnt_q <= CW'(CAPACITY), "count above capacity")
  `IMHRQ_ASSERT_NEXT(a_take_dequeues, cmd_i.take, !queued_q[$past(rm_h)], "handle still queued")
  `IMHRQ_ASSERT_IMPL(a_down_in_range, cmd_i.down_swap, left_ok, "sift down past the heap end")

endmodule
